// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the RTL. They compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/ltcq_pkg.sv =====
// ----------------------------------------------------------------------------
// ltcq_pkg
// Shared types and fixed field widths of the LED timed command queue.
// ----------------------------------------------------------------------------
package ltcq_pkg;

    localparam int CHAN_W    = 2;
    localparam int LEVEL_W   = 7;
    localparam int HOLD_W    = 16;
    localparam int ENTRY_W   = LEVEL_W + HOLD_W;
    localparam int DUTY_OUTS = 4;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_TICK    = 1'b1
    } opcode_t;

    // classified item, front to back
    typedef struct packed
    {
        opcode_t             op;
        logic [CHAN_W-1:0]   channel;
        logic                bad_chan;
        logic [LEVEL_W-1:0]  level;
        logic [HOLD_W-1:0]   hold;
    } cmd_t;

    // one result transfer
    typedef struct packed
    {
        logic [DUTY_OUTS-1:0][LEVEL_W-1:0] duty;
        logic                              dropped;
    } res_t;

endpackage

// ===== rtl/ltcq_ram.sv =====
// ----------------------------------------------------------------------------
// ltcq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ltcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ltcq_front.sv =====
// ----------------------------------------------------------------------------
// ltcq_front
// Input side: takes items, checks the channel, saturates the level and
// buffers the classified command in a two-slot queue for the back end.
// ----------------------------------------------------------------------------
module ltcq_front #(
    parameter int CHANNELS  = 4,
    parameter int PWM_RANGE = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [ltcq_pkg::CHAN_W-1:0]   channel,
    input  logic [ltcq_pkg::LEVEL_W-1:0]  level,
    input  logic [ltcq_pkg::HOLD_W-1:0]   hold_ms,
    output logic                          cmd_valid,
    output ltcq_pkg::cmd_t                cmd,
    input  logic                          cmd_take
);

    localparam int SLOTS = 2;

    ltcq_pkg::cmd_t slot_reg [SLOTS];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    ltcq_pkg::cmd_t cls;
    logic           do_push;

    always_comb
    begin
        cls.op       = ltcq_pkg::opcode_t'(opcode);
        cls.channel  = channel;
        cls.bad_chan = (int'(channel) >= CHANNELS);
        cls.hold     = hold_ms;
        if (int'(level) > PWM_RANGE)
        begin
            cls.level = ltcq_pkg::LEVEL_W'(PWM_RANGE);
        end
        else
        begin
            cls.level = level;
        end
    end

    assign full      = (count_reg == 2'(SLOTS));
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    always_comb
    begin
        wr_ptr_next = do_push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !cmd_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && cmd_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/ltcq_back.sv =====
// ----------------------------------------------------------------------------
// ltcq_back
// Execution side: per-channel queue pointers and timers, the command RAM
// and a sequencer that walks the channels one by one on a tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltcq_back #(
    parameter int CHANNELS    = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  ltcq_pkg::cmd_t cmd,
    output logic           cmd_take,
    output logic           res_valid,
    output ltcq_pkg::res_t res,
    input  logic           res_ready
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QP_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = CHANNELS * QUEUE_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int LEVEL_W = ltcq_pkg::LEVEL_W;
    localparam int HOLD_W  = ltcq_pkg::HOLD_W;
    localparam int ENTRY_W = ltcq_pkg::ENTRY_W;

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LOAD = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CH_W-1:0]    idx_reg;
    logic [CH_W-1:0]    idx_next;
    logic               drop_reg;
    logic               drop_next;

    logic [QP_W-1:0]    head_reg [CHANNELS];
    logic [QP_W-1:0]    tail_reg [CHANNELS];
    logic [FILL_W-1:0]  fill_reg [CHANNELS];
    logic [HOLD_W-1:0]  time_reg [CHANNELS];
    logic [LEVEL_W-1:0] duty_reg [CHANNELS];

    // per-channel update at the selected channel
    logic [CH_W-1:0]    cur;
    logic [QP_W-1:0]    head_cur;
    logic [QP_W-1:0]    tail_cur;
    logic [FILL_W-1:0]  fill_cur;
    logic [HOLD_W-1:0]  time_cur;
    logic [HOLD_W-1:0]  time_dec;
    logic               head_we;
    logic               tail_we;
    logic               fill_we;
    logic [FILL_W-1:0]  fill_cur_next;
    logic               time_we;
    logic [HOLD_W-1:0]  time_cur_next;
    logic               duty_we;
    logic [LEVEL_W-1:0] duty_cur_next;

    logic               enq_drop;
    logic               last_ch;
    logic [AW-1:0]      base;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [AW-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    function automatic logic [QP_W-1:0] advance(input logic [QP_W-1:0] p);
        advance = (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cur      = (state_reg == S_IDLE) ? CH_W'(cmd.channel) : idx_reg;
    assign head_cur = head_reg[cur];
    assign tail_cur = tail_reg[cur];
    assign fill_cur = fill_reg[cur];
    assign time_cur = time_reg[cur];
    assign time_dec = (time_cur != '0) ? time_cur - 1'b1 : '0;
    assign enq_drop = cmd.bad_chan || (fill_cur == FILL_W'(QUEUE_DEPTH));
    assign last_ch  = (idx_reg == CH_W'(CHANNELS - 1));
    assign base     = AW'(cur) * AW'(QUEUE_DEPTH);

    assign cmd_take    = (state_reg == S_IDLE) && cmd_valid;
    assign ram_wr_en   = cmd_take && (cmd.op == ltcq_pkg::OP_ENQUEUE) && !enq_drop;
    assign ram_rd_en   = (state_reg == S_SCAN) && (time_dec == '0) && (fill_cur != '0);
    assign ram_wr_addr = base + AW'(tail_cur);
    assign ram_rd_addr = base + AW'(head_cur);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        drop_next     = drop_reg;
        head_we       = 1'b0;
        tail_we       = 1'b0;
        fill_we       = 1'b0;
        fill_cur_next = fill_cur;
        time_we       = 1'b0;
        time_cur_next = time_cur;
        duty_we       = 1'b0;
        duty_cur_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == ltcq_pkg::OP_ENQUEUE)
                    begin
                        drop_next     = enq_drop;
                        tail_we       = !enq_drop;
                        fill_we       = !enq_drop;
                        fill_cur_next = fill_cur + 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        drop_next  = 1'b0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                time_we       = 1'b1;
                time_cur_next = time_dec;
                if (ram_rd_en)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    // still counting, or expired with nothing queued
                    duty_we       = (time_dec == '0);
                    duty_cur_next = '0;
                    if (last_ch)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                duty_we       = 1'b1;
                duty_cur_next = ram_rd_data[ENTRY_W-1:HOLD_W];
                time_we       = 1'b1;
                time_cur_next = ram_rd_data[HOLD_W-1:0];
                head_we       = 1'b1;
                fill_we       = 1'b1;
                fill_cur_next = fill_cur - 1'b1;
                if (last_ch)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
                time_reg[c] <= '0;
                duty_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
            if (head_we)
            begin
                head_reg[cur] <= advance(head_cur);
            end
            if (tail_we)
            begin
                tail_reg[cur] <= advance(tail_cur);
            end
            if (fill_we)
            begin
                fill_reg[cur] <= fill_cur_next;
            end
            if (time_we)
            begin
                time_reg[cur] <= time_cur_next;
            end
            if (duty_we)
            begin
                duty_reg[cur] <= duty_cur_next;
            end
        end
    end

    ltcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({cmd.level, cmd.hold}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_valid   = (state_reg == S_EMIT);
    assign res.dropped = drop_reg;

    for (genvar d = 0; d < ltcq_pkg::DUTY_OUTS; d++)
    begin : g_duty
        if (d < CHANNELS)
        begin : g_live
            assign res.duty[d] = duty_reg[d];
        end
        else
        begin : g_none
            assign res.duty[d] = '0;
        end
    end

    // a load always follows a read and only pops a nonempty queue
    `ASSERT_PROP(a_rd_then_load, clk, rst_n, ram_rd_en |=> (state_reg == S_LOAD), "read not followed by load")
    `ASSERT_PROP(a_load_nonempty, clk, rst_n, (state_reg == S_LOAD) |-> (fill_reg[idx_reg] != '0), "pop from empty queue")
    `ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, ram_wr_en && ram_rd_en, "store read and write in one cycle")

endmodule

// ===== rtl/led_timed_command_queue_core.sv =====
// ----------------------------------------------------------------------------
// led_timed_command_queue_core
// Four LED channels, each with a queue of (brightness, duration) commands,
// advanced by millisecond tick items. Every item gives one result transfer.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   -------   ---------  -------------  -------------------------------------
//   input     in         push / full    opcode, channel, level, hold_ms
//   result    out        empty / pop    duty_a..duty_d, dropped
//
// Enqueue: S_IDLE takes the item and writes the RAM, then S_EMIT gives the
// result; no new item is taken before S_EMIT is left. Tick: S_SCAN walks one
// channel per cycle, and a channel that pops adds S_LOAD for the single RAM
// read port. Results pass the input slot, S_EMIT and the result register.
// Stalls: the two-slot input queue takes items while the back end works; the
// result register holds the back end only while a result is not popped.
// Reset clears pointers, counts, timers and duty levels; the RAM needs no clear.
//
module led_timed_command_queue_core #(
    parameter int CHANNELS    = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int PWM_RANGE   = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [ltcq_pkg::CHAN_W-1:0]   channel,
    input  logic [ltcq_pkg::LEVEL_W-1:0]  level,
    input  logic [ltcq_pkg::HOLD_W-1:0]   hold_ms,
    output logic                          empty,
    input  logic                          pop,
    output logic [ltcq_pkg::LEVEL_W-1:0]  duty_a,
    output logic [ltcq_pkg::LEVEL_W-1:0]  duty_b,
    output logic [ltcq_pkg::LEVEL_W-1:0]  duty_c,
    output logic [ltcq_pkg::LEVEL_W-1:0]  duty_d,
    output logic                          dropped
);

    logic           cmd_valid;
    logic           cmd_take;
    ltcq_pkg::cmd_t cmd;
    logic           res_valid;
    logic           res_ready;
    ltcq_pkg::res_t res;

    // output stage
    ltcq_pkg::res_t out_reg;
    logic           out_valid_reg;
    logic           out_valid_next;

    // front: accept and classify (channel range check, level saturation)
    ltcq_front #(
        .CHANNELS  (CHANNELS),
        .PWM_RANGE (PWM_RANGE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .channel   (channel),
        .level     (level),
        .hold_ms   (hold_ms),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back: per-channel queues, timers and the tick sequencer
    ltcq_back #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // result register: refills in the same cycle it is popped
    assign res_ready = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign empty   = !out_valid_reg;
    assign duty_a  = out_reg.duty[0];
    assign duty_b  = out_reg.duty[1];
    assign duty_c  = out_reg.duty[2];
    assign duty_d  = out_reg.duty[3];
    assign dropped = out_reg.dropped;

endmodule
